/* rtl/sfp_pkg.sv */
package sfp_pkg;

    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int ADDR_W     = PTR_W + 1;      // channel bit on top of the slot index
    localparam int FILL_W     = 7;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [FILL_W-1:0] t_fill;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_GET   = 2'd1,
        MODE_STAGE = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_DROPPED = 3'd3,
        ST_NONE    = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        t_mode      mode;
        logic       channel;
        logic [7:0] data_in;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic [7:0] data_out;
        t_fill      main_fill;
        t_fill      staging_fill;
        logic       ready_res;
    } t_res;

    typedef struct packed {
        logic       we;
        t_addr      waddr;
        logic [7:0] wdata;
        t_addr      raddr;
    } t_ram_req;

    function automatic t_ptr ptr_next(input t_ptr p);
        t_ptr q;
        if (p == t_ptr'(FIFO_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + t_ptr'(1);
        end
        return q;
    endfunction

endpackage

/* rtl/sfp_ram.sv */
module sfp_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_W];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sfp_ctrl.sv */
module sfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sfp_pkg::t_req     i_req,
    input  logic [7:0]        i_stg_rdata,
    input  logic [7:0]        i_main_rdata,
    output logic              o_busy,
    output logic              o_res_valid,
    output sfp_pkg::t_res     o_res,
    output sfp_pkg::t_ram_req o_stg_ram,
    output sfp_pkg::t_ram_req o_main_ram
);

    sfp_pkg::t_state r_state, n_state;

    sfp_pkg::t_ptr r_stg_head  [2];
    sfp_pkg::t_ptr r_stg_tail  [2];
    sfp_pkg::t_ptr r_main_head [2];
    sfp_pkg::t_ptr r_main_tail [2];
    sfp_pkg::t_cnt r_stg_cnt   [2];
    sfp_pkg::t_cnt r_main_cnt  [2];

    sfp_pkg::t_ptr n_stg_head, n_stg_tail, n_main_head, n_main_tail;
    sfp_pkg::t_cnt n_stg_cnt, n_main_cnt;

    // result and deferred main write, held for the result cycle
    sfp_pkg::t_status r_status, n_status;
    sfp_pkg::t_fill   r_main_fill, n_main_fill;
    sfp_pkg::t_fill   r_stg_fill, n_stg_fill;
    logic             r_ready, n_ready;
    logic             r_get_ok, n_get_ok;
    logic             r_move, n_move;
    sfp_pkg::t_addr   r_move_addr, n_move_addr;

    logic accept;
    logic ch;
    logic stg_we;
    logic main_we;

    assign accept = i_start && (r_state == sfp_pkg::S_IDLE);
    assign ch     = i_req.channel;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfp_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = sfp_pkg::S_EXEC;
                end
            end
            sfp_pkg::S_EXEC: begin
                n_state = sfp_pkg::S_IDLE;
            end
            default: n_state = sfp_pkg::S_IDLE;
        endcase
    end

    // state-machine outputs
    always_comb begin
        o_busy      = 1'b0;
        o_res_valid = 1'b0;
        main_we     = 1'b0;
        unique case (r_state)
            sfp_pkg::S_IDLE: begin
                o_busy = 1'b0;
            end
            sfp_pkg::S_EXEC: begin
                o_busy      = 1'b1;
                o_res_valid = 1'b1;
                main_we     = r_move;
            end
            default: o_busy = 1'b0;
        endcase
    end

    // pointer, count and status update for the request being taken
    always_comb begin
        n_stg_head  = r_stg_head[ch];
        n_stg_tail  = r_stg_tail[ch];
        n_main_head = r_main_head[ch];
        n_main_tail = r_main_tail[ch];
        n_stg_cnt   = r_stg_cnt[ch];
        n_main_cnt  = r_main_cnt[ch];
        n_status    = sfp_pkg::ST_OK;
        n_get_ok    = 1'b0;
        n_move      = 1'b0;
        n_move_addr = {ch, r_main_tail[ch]};
        stg_we      = 1'b0;

        unique case (i_req.mode)
            sfp_pkg::MODE_PUT: begin
                if (r_stg_cnt[ch] >= sfp_pkg::t_cnt'(sfp_pkg::FIFO_DEPTH)) begin
                    n_status = sfp_pkg::ST_FULL;
                end else begin
                    stg_we     = accept;
                    n_stg_tail = sfp_pkg::ptr_next(r_stg_tail[ch]);
                    n_stg_cnt  = r_stg_cnt[ch] + sfp_pkg::t_cnt'(1);
                end
            end
            sfp_pkg::MODE_GET: begin
                if (r_main_cnt[ch] == '0) begin
                    n_status = sfp_pkg::ST_EMPTY;
                end else begin
                    n_get_ok    = 1'b1;
                    n_main_head = sfp_pkg::ptr_next(r_main_head[ch]);
                    n_main_cnt  = r_main_cnt[ch] - sfp_pkg::t_cnt'(1);
                end
            end
            sfp_pkg::MODE_STAGE: begin
                if (r_stg_cnt[ch] == '0) begin
                    n_status = sfp_pkg::ST_NONE;
                end else begin
                    n_stg_head = sfp_pkg::ptr_next(r_stg_head[ch]);
                    n_stg_cnt  = r_stg_cnt[ch] - sfp_pkg::t_cnt'(1);
                    // main full: byte leaves staging and is lost
                    if (r_main_cnt[ch] >= sfp_pkg::t_cnt'(sfp_pkg::FIFO_DEPTH)) begin
                        n_status = sfp_pkg::ST_DROPPED;
                    end else begin
                        n_move      = 1'b1;
                        n_main_tail = sfp_pkg::ptr_next(r_main_tail[ch]);
                        n_main_cnt  = r_main_cnt[ch] + sfp_pkg::t_cnt'(1);
                    end
                end
            end
            sfp_pkg::MODE_NOP: begin
                n_status = sfp_pkg::ST_OK;
            end
            default: n_status = sfp_pkg::ST_OK;
        endcase

        n_main_fill = sfp_pkg::t_fill'(n_main_cnt);
        n_stg_fill  = sfp_pkg::t_fill'(n_stg_cnt);
        n_ready     = (n_main_cnt != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfp_pkg::S_IDLE;
            for (int i = 0; i < 2; i++) begin
                r_stg_head[i]  <= '0;
                r_stg_tail[i]  <= '0;
                r_main_head[i] <= '0;
                r_main_tail[i] <= '0;
                r_stg_cnt[i]   <= '0;
                r_main_cnt[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_stg_head[ch]  <= n_stg_head;
                r_stg_tail[ch]  <= n_stg_tail;
                r_main_head[ch] <= n_main_head;
                r_main_tail[ch] <= n_main_tail;
                r_stg_cnt[ch]   <= n_stg_cnt;
                r_main_cnt[ch]  <= n_main_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_main_fill <= n_main_fill;
            r_stg_fill  <= n_stg_fill;
            r_ready     <= n_ready;
            r_get_ok    <= n_get_ok;
            r_move      <= n_move;
            r_move_addr <= n_move_addr;
        end
    end

    // reads are issued on the accept edge; data lands for the result cycle
    assign o_stg_ram.we     = stg_we;
    assign o_stg_ram.waddr  = {ch, r_stg_tail[ch]};
    assign o_stg_ram.wdata  = i_req.data_in;
    assign o_stg_ram.raddr  = {ch, r_stg_head[ch]};

    assign o_main_ram.we    = main_we;
    assign o_main_ram.waddr = r_move_addr;
    assign o_main_ram.wdata = i_stg_rdata;
    assign o_main_ram.raddr = {ch, r_main_head[ch]};

    assign o_res.status       = r_status;
    assign o_res.data_out     = r_get_ok ? i_main_rdata : 8'd0;
    assign o_res.main_fill    = r_main_fill;
    assign o_res.staging_fill = r_stg_fill;
    assign o_res.ready_res    = r_ready;

endmodule

/* rtl/staged_fifo_pair.sv */
// The result strobe o_res_valid is high in the cycle after the request is taken.
// A new request is not taken while the last one's result is shown; busy is high during
// the result cycle, in which the data read from the staging and main stores arrives.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active low) clears pointers, fill counts and the FSM;
// store contents are not cleared.
module staged_fifo_pair (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  sfp_pkg::t_req i_req,
    output logic          busy,
    output logic          o_res_valid,
    output sfp_pkg::t_res o_res
);

    sfp_pkg::t_ram_req stg_ram;
    sfp_pkg::t_ram_req main_ram;
    logic [7:0]        stg_rdata;
    logic [7:0]        main_rdata;

    sfp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req        (i_req),
        .i_stg_rdata  (stg_rdata),
        .i_main_rdata (main_rdata),
        .o_busy       (busy),
        .o_res_valid  (o_res_valid),
        .o_res        (o_res),
        .o_stg_ram    (stg_ram),
        .o_main_ram   (main_ram)
    );

    sfp_ram #(
        .WIDTH  (8),
        .ADDR_W (sfp_pkg::ADDR_W)
    ) u_stg_ram (
        .i_clk   (i_clk),
        .i_we    (stg_ram.we),
        .i_waddr (stg_ram.waddr),
        .i_wdata (stg_ram.wdata),
        .i_raddr (stg_ram.raddr),
        .o_rdata (stg_rdata)
    );

    sfp_ram #(
        .WIDTH  (8),
        .ADDR_W (sfp_pkg::ADDR_W)
    ) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (main_ram.we),
        .i_waddr (main_ram.waddr),
        .i_wdata (main_ram.wdata),
        .i_raddr (main_ram.raddr),
        .o_rdata (main_rdata)
    );

endmodule

/* rtl/sfp_chk.sv */
module sfp_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input sfp_pkg::t_req i_req,
    input logic          busy,
    input logic          o_res_valid,
    input sfp_pkg::t_res o_res
);

    // every request taken gives a result in the next cycle
    a_res_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_res_valid)
        else $error("no result after request");

    // no result without a request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_res_valid)
        else $error("result without request");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> busy)
        else $error("result shown while accepting");

    a_ready_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.ready_res == (o_res.main_fill != '0)))
        else $error("ready flag disagrees with main fill");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.status == sfp_pkg::ST_EMPTY) |-> (o_res.data_out == 8'd0))
        else $error("empty get returned data");

endmodule

bind staged_fifo_pair sfp_chk u_sfp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .i_req       (i_req),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);
